### src/display_init_list_sequencer_top_macros.svh
// ----------------------------------------------------------------------------
// display init list sequencer assertion macros
// concurrent checks sampled on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef DISPLAY_INIT_LIST_SEQUENCER_TOP_MACROS_SVH
`define DISPLAY_INIT_LIST_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define DILS_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dils assertion failed");

// next-cycle implication
`define DILS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dils assertion failed");

`endif

### src/dils_pkg.sv
// ----------------------------------------------------------------------------
// dils_pkg
// types and constants shared by the display init list sequencer
// ----------------------------------------------------------------------------
package dils_pkg;

  // parser phase codes
  localparam logic [2:0] PhCount = 3'd0;
  localparam logic [2:0] PhCmd   = 3'd1;
  localparam logic [2:0] PhArgc  = 3'd2;
  localparam logic [2:0] PhParam = 3'd3;
  localparam logic [2:0] PhDelay = 3'd4;

  // result kinds
  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindCmd   = 2'd1;
  localparam logic [1:0] KindParam = 2'd2;
  localparam logic [1:0] KindDelay = 2'd3;

  localparam int unsigned DelayFlagBit = 7;
  localparam logic [7:0] LongDelayCode = 8'd255;
  localparam logic [8:0] LongDelayMs   = 9'd500;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] commands_left;
    logic [6:0] args_left;
    logic       delay_pending;
  } parse_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       data_not_command;
    logic       last_of_transfer;
    logic [8:0] delay_ms;
    logic       list_end;
  } result_t;

endpackage

### src/dils_step.sv
// ----------------------------------------------------------------------------
// dils_step
// decodes one list byte against the parser state: gives the result and the
// state that follows
// ----------------------------------------------------------------------------
module dils_step (
  input  dils_pkg::parse_state_t state_i,
  input  logic [7:0]             list_byte_i,
  output dils_pkg::parse_state_t state_o,
  output dils_pkg::result_t      result_o
);

  logic [7:0] cmds_dec;
  logic [6:0] args_dec;
  logic [6:0] argc_field;
  logic       argc_delay;

  assign cmds_dec   = state_i.commands_left - 8'd1;
  assign args_dec   = state_i.args_left - 7'd1;
  assign argc_field = list_byte_i[6:0];
  assign argc_delay = list_byte_i[dils_pkg::DelayFlagBit];

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    case (state_i.phase)
      dils_pkg::PhCmd: begin
        result_o.kind     = dils_pkg::KindCmd;
        result_o.out_byte = list_byte_i;
        state_o.phase     = dils_pkg::PhArgc;
      end
      dils_pkg::PhArgc: begin
        state_o.delay_pending = argc_delay;
        state_o.args_left     = argc_field;
        if (argc_field != 7'd0) begin
          state_o.phase = dils_pkg::PhParam;
        end else if (argc_delay) begin
          state_o.phase = dils_pkg::PhDelay;
        end else begin
          // command with nothing after it closes here
          state_o.commands_left = cmds_dec;
          state_o.delay_pending = 1'b0;
          result_o.list_end     = (cmds_dec == 8'd0);
          state_o.phase = (cmds_dec == 8'd0) ? dils_pkg::PhCount : dils_pkg::PhCmd;
        end
      end
      dils_pkg::PhParam: begin
        result_o.kind             = dils_pkg::KindParam;
        result_o.out_byte         = list_byte_i;
        result_o.data_not_command = 1'b1;
        state_o.args_left         = args_dec;
        if (args_dec == 7'd0) begin
          result_o.last_of_transfer = 1'b1;
          if (state_i.delay_pending) begin
            state_o.phase = dils_pkg::PhDelay;
          end else begin
            state_o.commands_left = cmds_dec;
            result_o.list_end     = (cmds_dec == 8'd0);
            state_o.phase = (cmds_dec == 8'd0) ? dils_pkg::PhCount : dils_pkg::PhCmd;
          end
        end
      end
      dils_pkg::PhDelay: begin
        result_o.kind     = dils_pkg::KindDelay;
        result_o.delay_ms = (list_byte_i == dils_pkg::LongDelayCode) ?
                            dils_pkg::LongDelayMs : {1'b0, list_byte_i};
        state_o.commands_left = cmds_dec;
        state_o.delay_pending = 1'b0;
        result_o.list_end     = (cmds_dec == 8'd0);
        state_o.phase = (cmds_dec == 8'd0) ? dils_pkg::PhCount : dils_pkg::PhCmd;
      end
      default: begin
        // command count byte, also taken for unused phase codes
        state_o.commands_left = list_byte_i;
        state_o.args_left     = 7'd0;
        state_o.delay_pending = 1'b0;
        result_o.list_end     = (list_byte_i == 8'd0);
        state_o.phase = (list_byte_i == 8'd0) ? dils_pkg::PhCount : dils_pkg::PhCmd;
      end
    endcase
  end

endmodule

### src/display_init_list_sequencer_top.sv
// ----------------------------------------------------------------------------
// display_init_list_sequencer_top
// parses a packed display init list, one byte per request, into command,
// parameter and delay requests
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_stall_o   | list_byte_i
//  out     | output    | out_valid_o / out_stall_i | kind_o, out_byte_o,
//          |           |                           | data_not_command_o,
//          |           |                           | last_of_transfer_o,
//          |           |                           | delay_ms_o, list_end_o
//
// one byte per cycle sustained while out_stall_i is low; a byte is taken into the
// input register, then decoded into the result register with the parser state
// reset clears the parser state and both valid flags, next byte is a count
// out_stall_i holds the result register; the input register can still take one
// byte while the result register waits, and in_stall_o rises only when both
// are full
// ----------------------------------------------------------------------------
`include "display_init_list_sequencer_top_macros.svh"

module display_init_list_sequencer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] list_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       data_not_command_o,
  output logic       last_of_transfer_o,
  output logic [8:0] delay_ms_o,
  output logic       list_end_o
);

  logic                   in_valid_q;
  logic [7:0]             in_byte_q;
  logic                   out_valid_q;
  dils_pkg::result_t      result_q;
  dils_pkg::result_t      result_d;
  dils_pkg::parse_state_t state_q;
  dils_pkg::parse_state_t state_d;
  logic                   out_free;
  logic                   advance;
  logic                   in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  dils_step u_step (
    .state_i     (state_q),
    .list_byte_i (in_byte_q),
    .state_o     (state_d),
    .result_o    (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: dils_pkg::PhCount, commands_left: 8'd0,
                       args_left: 7'd0, delay_pending: 1'b0};
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= list_byte_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = result_q.kind;
  assign out_byte_o         = result_q.out_byte;
  assign data_not_command_o = result_q.data_not_command;
  assign last_of_transfer_o = result_q.last_of_transfer;
  assign delay_ms_o         = result_q.delay_ms;
  assign list_end_o         = result_q.list_end;

  `DILS_ASSERT(a_count_clean, state_q.phase == dils_pkg::PhCount,
    state_q.args_left == 7'd0 && !state_q.delay_pending)
  `DILS_ASSERT(a_param_has_args, state_q.phase == dils_pkg::PhParam,
    state_q.args_left != 7'd0)
  `DILS_ASSERT(a_cmds_live, state_q.phase != dils_pkg::PhCount,
    state_q.commands_left != 8'd0)
  `DILS_ASSERT_NEXT(a_advance_shows, advance, out_valid_q)

endmodule
